### src/assert_macros.svh
// Assertion macros used by the top level of the maze row generator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition in the same cycle as its trigger
`define EMR_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a condition in the cycle after its trigger
`define EMR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### src/emr_pkg.sv
// Shared types, constants and helpers of the maze row generator
package emr_pkg;

  localparam int COLUMNS = 16;
  localparam int IDX_W   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int RCOIN_W = 15;
  localparam int DCOIN_W = 16;
  localparam int WALL_W  = 16;

  typedef logic [IDX_W-1:0] col_t;

  localparam col_t LAST_COL = col_t'(COLUMNS - 1);

  typedef struct packed {
    logic [RCOIN_W-1:0] right_coins;
    logic [DCOIN_W-1:0] down_coins;
    logic               final_row;
  } in_item_t;

  typedef struct packed {
    logic [WALL_W-1:0] right_wall_bits;
    logic [WALL_W-1:0] down_wall_bits;
  } out_item_t;

  // Operation broadcast to every cell
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_SCAN,
    OP_DOWN,
    OP_INIT
  } cell_op_t;

  // Control seen by every cell, decoded from the sequencer's registers
  typedef struct packed {
    cell_op_t op;
    col_t     pos;
  } cell_ctl_t;

  // Decision made from the visited cell, sent back to all cells
  typedef struct packed {
    logic merge;
    logic claim;
    logic own;
    col_t keep;
    col_t drop;
  } bcast_t;

  // Report of the visited cell; zero from all other cells
  typedef struct packed {
    logic diff;
    logic claimed;
    col_t label;
    col_t left;
  } cell_rpt_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic busy;
    logic load;
    logic final_row;
  } seq_stat_t;

  // Spread the right coins over the columns; the last column has none
  function automatic logic [COLUMNS-1:0] widen_right(input logic [RCOIN_W-1:0] v);
    logic [COLUMNS-1:0] r;
    r = '0;
    for (int i = 0; i < COLUMNS - 1; i++) begin
      if (i < RCOIN_W) r[i] = v[i];
    end
    return r;
  endfunction

  // Spread the down coins over the columns; missing bits read as zero
  function automatic logic [COLUMNS-1:0] widen_down(input logic [DCOIN_W-1:0] v);
    logic [COLUMNS-1:0] r;
    r = '0;
    for (int i = 0; i < COLUMNS; i++) begin
      if (i < DCOIN_W) r[i] = v[i];
    end
    return r;
  endfunction

  // Fit a column vector into an output field; extra bits are dropped
  function automatic logic [WALL_W-1:0] fit_wall(input logic [COLUMNS-1:0] w);
    logic [WALL_W-1:0] r;
    r = '0;
    for (int i = 0; i < WALL_W; i++) begin
      if (i < COLUMNS) r[i] = w[i];
    end
    return r;
  endfunction

endpackage

### src/emr_cell.sv
// One column cell: holds the set label and hands it to the right neighbor
module emr_cell import emr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  col_t      idx,
  input  col_t      left_label,
  input  cell_ctl_t ctl,
  input  bcast_t    bc,
  output col_t      label,
  output cell_rpt_t rpt
);

  logic claimed;
  logic active;

  assign active = (ctl.pos == idx);

  // Report own state only while visited
  always_comb begin
    rpt = '0;
    if (active) begin
      rpt.diff    = (left_label != label);
      rpt.claimed = claimed;
      rpt.label   = label;
      rpt.left    = left_label;
    end
  end

  // Relabel on merge, claim, taking its own index, or restart
  always_ff @(posedge clk) begin
    if (rst) begin
      label   <= idx;
      claimed <= 1'b0;
    end else begin
      case (ctl.op)
        OP_SCAN: begin
          claimed <= 1'b0;
          if (bc.merge && (label == bc.drop)) label <= bc.keep;
        end
        OP_DOWN: begin
          if (active) begin
            if (bc.own) label <= idx;
          end else if (bc.claim && !claimed && (label == bc.drop) && (idx > ctl.pos)) begin
            label   <= bc.keep;
            claimed <= 1'b1;
          end
        end
        OP_INIT: begin
          label   <= idx;
          claimed <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

### src/emr_seq.sv
// Column sequencer: walks the cells and builds the wall vectors of a row
module emr_seq import emr_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  in_item_t           item,
  input  logic               out_free,
  input  cell_rpt_t          rpt [COLUMNS],
  output cell_ctl_t          ctl,
  output bcast_t             bc,
  output logic [COLUMNS-1:0] res_right,
  output logic [COLUMNS-1:0] res_down,
  output seq_stat_t          stat
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_JOIN = 5'b00100,
    S_DOWN = 5'b01000,
    S_DONE = 5'b10000
  } seq_state_t;

  seq_state_t         state;
  col_t               pos;
  col_t               prev;
  logic [COLUMNS-1:0] rcoin;
  logic [COLUMNS-1:0] dcoin;
  logic               final_q;
  logic [COLUMNS-1:0] right_w;
  logic [COLUMNS-1:0] down_w;
  cell_rpt_t          rep;
  logic               coin_r;
  logic               closed;

  assign prev   = pos - col_t'(1);
  assign coin_r = rcoin[prev];
  assign closed = rep.claimed & dcoin[pos];

  // Collect the visited cell's report
  always_comb begin
    rep = '0;
    for (int i = 0; i < COLUMNS; i++) rep = rep | rpt[i];
  end

  // Drive the cell operation from the state
  always_comb begin
    ctl.pos = pos;
    case (state)
      S_SCAN:  ctl.op = OP_SCAN;
      S_JOIN:  ctl.op = OP_SCAN;
      S_DOWN:  ctl.op = OP_DOWN;
      S_DONE:  ctl.op = final_q ? OP_INIT : OP_HOLD;
      default: ctl.op = OP_HOLD;
    endcase
  end

  // Decide merges and claims from the visited cell
  always_comb begin
    bc = '0;
    case (state)
      S_SCAN: begin
        bc.merge = rep.diff & ~coin_r;
        bc.keep  = rep.left;
        bc.drop  = rep.label;
      end
      S_JOIN: begin
        bc.merge = rep.diff;
        bc.keep  = rep.left;
        bc.drop  = rep.label;
      end
      S_DOWN: begin
        bc.claim = ~rep.claimed;
        bc.own   = ~rep.claimed | closed;
        bc.keep  = pos;
        bc.drop  = rep.label;
      end
      default: ;
    endcase
  end

  // Advance through the passes of one row
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      pos   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            state <= S_SCAN;
            pos   <= col_t'(1);
          end
        end
        S_SCAN: begin
          if (pos == LAST_COL) begin
            state <= final_q ? S_JOIN : S_DOWN;
            pos   <= final_q ? col_t'(1) : '0;
          end else begin
            pos <= pos + col_t'(1);
          end
        end
        S_JOIN: begin
          if (pos == LAST_COL) state <= S_DONE;
          else pos <= pos + col_t'(1);
        end
        S_DOWN: begin
          if (pos == LAST_COL) state <= S_DONE;
          else pos <= pos + col_t'(1);
        end
        S_DONE: begin
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the coins and build the wall bits
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          rcoin   <= widen_right(item.right_coins);
          dcoin   <= widen_down(item.down_coins);
          final_q <= item.final_row;
          right_w <= {1'b1, {(COLUMNS-1){1'b0}}};
          down_w  <= item.final_row ? '1 : '0;
        end
      end
      S_SCAN:  right_w[prev] <= ~rep.diff | coin_r;
      S_JOIN:  if (rep.diff) right_w[prev] <= 1'b0;
      S_DOWN:  down_w[pos] <= closed;
      default: ;
    endcase
  end

  assign res_right      = right_w;
  assign res_down       = down_w;
  assign stat.busy      = (state != S_IDLE);
  assign stat.load      = (state == S_DONE) & out_free;
  assign stat.final_row = final_q;

endmodule

### src/eller_maze_row_generator_unit.sv
// An accepted row goes through a merge pass and then a down pass, or a join pass
// on a final row, and its result waits while an older result is still held.
// A new row is taken only once the last result is loaded; the sequencer visits
// one column cell per cycle in each pass.
// The result register frees the cell row while a result waits to be taken.
// Reset: synchronous, active high; every column gets its own label, no result pending.
`include "assert_macros.svh"

module eller_maze_row_generator_unit import emr_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cell_ctl_t          ctl;
  bcast_t             bc;
  cell_rpt_t          rpt [COLUMNS];
  col_t               labels [COLUMNS];
  logic [COLUMNS-1:0] res_right;
  logic [COLUMNS-1:0] res_down;
  seq_stat_t          stat;
  logic               out_free;
  logic               start;

  assign in_ready = ~stat.busy;
  assign start    = in_valid & in_ready;
  assign out_free = ~out_valid | out_ready;

  // Row of column cells, each fed by its left neighbor
  for (genvar i = 0; i < COLUMNS; i++) begin : g_cell
    col_t left_label;
    if (i == 0) begin : g_first
      assign left_label = '0;
    end else begin : g_rest
      assign left_label = labels[i-1];
    end
    emr_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .idx        (col_t'(i)),
      .left_label (left_label),
      .ctl        (ctl),
      .bc         (bc),
      .label      (labels[i]),
      .rpt        (rpt[i])
    );
  end

  emr_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (in_data),
    .out_free  (out_free),
    .rpt       (rpt),
    .ctl       (ctl),
    .bc        (bc),
    .res_right (res_right),
    .res_down  (res_down),
    .stat      (stat)
  );

  // Hold the result beat until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (stat.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.load) begin
      out_data.right_wall_bits <= fit_wall(res_right);
      out_data.down_wall_bits  <= fit_wall(res_down);
    end
  end

  `EMR_ASSERT_NEXT(a_busy_after_accept, start, !in_ready && stat.busy, "row accepted while busy")
  `EMR_ASSERT_NEXT(a_load_shows, stat.load, out_valid, "loaded result not shown")
  `EMR_ASSERT_NEXT(a_final_down, stat.load && stat.final_row, out_data.down_wall_bits == fit_wall('1), "final row down walls not closed")
  `EMR_ASSERT_NOW(a_no_overwrite, stat.load, !out_valid || out_ready, "result overwritten")

endmodule
